// ===== rtl/lps_pkg.sv =====
package lps_pkg;

    typedef enum logic [3:0] {
        ACT_PUSH_FRONT = 4'd0,
        ACT_PUSH_BACK  = 4'd1,
        ACT_POP_FRONT  = 4'd2,
        ACT_POP_BACK   = 4'd3,
        ACT_INSERT     = 4'd4,
        ACT_REMOVE     = 4'd5,
        ACT_REPLACE    = 4'd6,
        ACT_READ       = 4'd7,
        ACT_CONTAINS   = 4'd8,
        ACT_CLEAR      = 4'd9
    } act_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_RANGE = 2'd2,
        ERR_FULL  = 2'd3
    } err_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TAKE_RD,
        ST_TAKE_GRAB,
        ST_DN_RD,
        ST_DN_WR,
        ST_UP_RD,
        ST_UP_WR,
        ST_PUT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DONE
    } state_t;

    // one finished request as handed to the output register
    typedef struct packed {
        logic [31:0] data;
        logic [4:0]  count;
        logic        found;
        err_t        error;
    } res_t;

endpackage

// ===== rtl/lps_if.sv =====
interface lps_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic [4:0]  position;
    logic [31:0] value;

    modport source (output valid, action, position, value, input ready);
    modport sink (input valid, action, position, value, output ready);
endinterface

interface lps_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    logic [4:0]  count;
    logic        found;
    logic [1:0]  error;

    modport source (output valid, data, count, found, error, input ready);
    modport sink (input valid, data, count, found, error, output ready);
endinterface

// ===== rtl/positional_list_store_top.sv =====
// Ordered list of up to DEPTH words of DATA_W bits, kept in list order in a
// single-port-write / single-port-read memory (index 0 is the front). Each
// request on req yields exactly one beat on rsp with data, the count after
// the request, a found flag and an error code; a failing request leaves the
// list untouched. One request is in flight at a time: req.ready is high
// only while the sequencer is idle. Pushes and insert shift the entries
// from the position on up by one; pops and remove shift the entries after
// the removed one down; contains scans from the front until a hit or the
// end; clear, no-op, read, replace and failing requests move nothing.
// Time per request is set by the one memory read port: every entry that
// moves or is compared is first read (registered read data) and then
// written or compared. The result sits in an output register, so a
// waiting rsp only stalls the next request once that register is still
// full when the next result is ready.
module positional_list_store_top #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    lps_req_if.sink   req,
    lps_rsp_if.source rsp
);

    localparam int AW = $clog2(DEPTH);

    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    logic [DATA_W-1:0] wdata, rdata;
    logic              res_valid, res_take;
    lps_pkg::res_t     res;

    // output register
    logic          rsp_valid_reg, rsp_valid_next;
    lps_pkg::res_t rsp_res_reg, rsp_res_next;

    lps_ctrl #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take),
        .we        (we),
        .waddr     (waddr),
        .wdata     (wdata),
        .re        (re),
        .raddr     (raddr),
        .rdata     (rdata)
    );

    lps_store #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // load a finished result whenever the output slot is free or draining
    assign res_take = res_valid && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_res_next   = rsp_res_reg;
        if (res_take)
        begin
            rsp_valid_next = 1'b1;
            rsp_res_next   = res;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_res_reg <= rsp_res_next;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_res_reg.data;
    assign rsp.count = rsp_res_reg.count;
    assign rsp.found = rsp_res_reg.found;
    assign rsp.error = rsp_res_reg.error;

endmodule

// ===== rtl/lps_store.sv =====
module lps_store #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 32,
    parameter int AW     = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lps_ctrl.sv =====
module lps_ctrl #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 32,
    parameter int AW     = $clog2(DEPTH),
    parameter int CW     = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    lps_req_if.sink           req,
    output logic              res_valid,
    output lps_pkg::res_t     res,
    input  logic              res_take,
    output logic              we,
    output logic [AW-1:0]     waddr,
    output logic [DATA_W-1:0] wdata,
    output logic              re,
    output logic [AW-1:0]     raddr,
    input  logic [DATA_W-1:0] rdata
);

    lps_pkg::state_t state_reg, state_next;
    lps_pkg::act_t   op_reg, op_next;
    lps_pkg::err_t   err_reg, err_next;
    logic [CW-1:0]     occ_reg, occ_next;
    logic [AW-1:0]     at_reg, at_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic              found_reg, found_next;

    lps_pkg::act_t act;
    lps_pkg::err_t acc_err;
    logic [AW-1:0] acc_at;
    logic          full, empty, acc_up;
    logic          take_more, dn_more, up_more, scan_more, hit, keeps_place;
    int            occ_i, pos_i;

    assign act   = lps_pkg::act_t'(req.action);
    assign occ_i = int'(occ_reg);
    assign pos_i = int'(req.position);
    assign full  = (occ_reg == CW'(DEPTH));
    assign empty = (occ_reg == '0);

    // shared index compare / step
    assign take_more = (int'(at_reg) + 1) < occ_i;
    assign dn_more   = (int'(idx_reg) + 2) < occ_i;
    assign up_more   = (int'(idx_reg) - 1) > int'(at_reg);
    assign scan_more = (int'(idx_reg) + 1) < occ_i;
    assign hit       = (rdata == val_reg);
    assign keeps_place = (op_reg == lps_pkg::ACT_REPLACE) || (op_reg == lps_pkg::ACT_READ);
    assign acc_up    = int'(acc_at) < occ_i;

    // request check at accept
    always_comb
    begin
        acc_err = lps_pkg::ERR_OK;
        acc_at  = '0;
        case (act)
            lps_pkg::ACT_PUSH_FRONT:
            begin
                if (full) acc_err = lps_pkg::ERR_FULL;
            end
            lps_pkg::ACT_PUSH_BACK:
            begin
                if (full) acc_err = lps_pkg::ERR_FULL;
                acc_at = AW'(occ_reg);
            end
            lps_pkg::ACT_POP_FRONT:
            begin
                if (empty) acc_err = lps_pkg::ERR_EMPTY;
            end
            lps_pkg::ACT_POP_BACK:
            begin
                if (empty) acc_err = lps_pkg::ERR_EMPTY;
                acc_at = AW'(occ_reg - CW'(1));
            end
            lps_pkg::ACT_INSERT:
            begin
                if (pos_i > occ_i) acc_err = lps_pkg::ERR_RANGE;
                else if (full) acc_err = lps_pkg::ERR_FULL;
                acc_at = AW'(req.position);
            end
            lps_pkg::ACT_REMOVE, lps_pkg::ACT_READ:
            begin
                if (pos_i >= occ_i) acc_err = lps_pkg::ERR_RANGE;
                acc_at = AW'(req.position);
            end
            lps_pkg::ACT_REPLACE:
            begin
                if (empty) acc_err = lps_pkg::ERR_EMPTY;
                else if (pos_i >= occ_i) acc_err = lps_pkg::ERR_RANGE;
                acc_at = AW'(req.position);
            end
            default:
            begin
                acc_err = lps_pkg::ERR_OK;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lps_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (acc_err != lps_pkg::ERR_OK)
                    begin
                        state_next = lps_pkg::ST_DONE;
                    end
                    else
                    begin
                        case (act)
                            lps_pkg::ACT_PUSH_FRONT, lps_pkg::ACT_PUSH_BACK,
                            lps_pkg::ACT_INSERT:
                                state_next = acc_up ? lps_pkg::ST_UP_RD : lps_pkg::ST_PUT;
                            lps_pkg::ACT_POP_FRONT, lps_pkg::ACT_POP_BACK,
                            lps_pkg::ACT_REMOVE, lps_pkg::ACT_REPLACE, lps_pkg::ACT_READ:
                                state_next = lps_pkg::ST_TAKE_RD;
                            lps_pkg::ACT_CONTAINS:
                                state_next = empty ? lps_pkg::ST_DONE : lps_pkg::ST_SCAN_RD;
                            default:
                                state_next = lps_pkg::ST_DONE;
                        endcase
                    end
                end
            end
            lps_pkg::ST_TAKE_RD:   state_next = lps_pkg::ST_TAKE_GRAB;
            lps_pkg::ST_TAKE_GRAB:
            begin
                if (!keeps_place && take_more) state_next = lps_pkg::ST_DN_RD;
                else                           state_next = lps_pkg::ST_DONE;
            end
            lps_pkg::ST_DN_RD:     state_next = lps_pkg::ST_DN_WR;
            lps_pkg::ST_DN_WR:
                state_next = dn_more ? lps_pkg::ST_DN_RD : lps_pkg::ST_DONE;
            lps_pkg::ST_UP_RD:     state_next = lps_pkg::ST_UP_WR;
            lps_pkg::ST_UP_WR:
                state_next = up_more ? lps_pkg::ST_UP_RD : lps_pkg::ST_PUT;
            lps_pkg::ST_PUT:       state_next = lps_pkg::ST_DONE;
            lps_pkg::ST_SCAN_RD:   state_next = lps_pkg::ST_SCAN_CMP;
            lps_pkg::ST_SCAN_CMP:
            begin
                if (!hit && scan_more) state_next = lps_pkg::ST_SCAN_RD;
                else                   state_next = lps_pkg::ST_DONE;
            end
            lps_pkg::ST_DONE:
            begin
                if (res_take) state_next = lps_pkg::ST_IDLE;
            end
            default:               state_next = lps_pkg::ST_IDLE;
        endcase
    end

    // outputs: handshake, memory port, result
    always_comb
    begin
        req.ready = (state_reg == lps_pkg::ST_IDLE);
        res_valid = (state_reg == lps_pkg::ST_DONE);
        we    = 1'b0;
        waddr = idx_reg;
        wdata = rdata;
        re    = 1'b0;
        raddr = idx_reg;
        case (state_reg)
            lps_pkg::ST_TAKE_RD:
            begin
                re    = 1'b1;
                raddr = at_reg;
            end
            lps_pkg::ST_TAKE_GRAB:
            begin
                we    = (op_reg == lps_pkg::ACT_REPLACE);
                waddr = at_reg;
                wdata = val_reg;
            end
            lps_pkg::ST_DN_RD:
            begin
                re    = 1'b1;
                raddr = idx_reg + AW'(1);
            end
            lps_pkg::ST_UP_RD:
            begin
                re    = 1'b1;
                raddr = idx_reg - AW'(1);
            end
            lps_pkg::ST_DN_WR, lps_pkg::ST_UP_WR:
            begin
                we = 1'b1;
            end
            lps_pkg::ST_PUT:
            begin
                we    = 1'b1;
                waddr = at_reg;
                wdata = val_reg;
            end
            lps_pkg::ST_SCAN_RD:
            begin
                re = 1'b1;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
        res.data  = 32'(data_reg);
        res.count = 5'(occ_reg);
        res.found = found_reg;
        res.error = err_reg;
    end

    // datapath registers
    always_comb
    begin
        op_next    = op_reg;
        err_next   = err_reg;
        occ_next   = occ_reg;
        at_next    = at_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        data_next  = data_reg;
        found_next = found_reg;
        case (state_reg)
            lps_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = act;
                    err_next   = acc_err;
                    at_next    = acc_at;
                    idx_next   = (act == lps_pkg::ACT_CONTAINS) ? '0 : AW'(occ_reg);
                    val_next   = DATA_W'(req.value);
                    data_next  = '0;
                    found_next = 1'b0;
                    if (act == lps_pkg::ACT_CLEAR) occ_next = '0;
                end
            end
            lps_pkg::ST_TAKE_GRAB:
            begin
                data_next = rdata;
                if (!keeps_place)
                begin
                    idx_next = at_reg;
                    if (!take_more) occ_next = occ_reg - CW'(1);
                end
            end
            lps_pkg::ST_DN_WR:
            begin
                idx_next = idx_reg + AW'(1);
                if (!dn_more) occ_next = occ_reg - CW'(1);
            end
            lps_pkg::ST_UP_WR:
            begin
                idx_next = idx_reg - AW'(1);
            end
            lps_pkg::ST_PUT:
            begin
                occ_next = occ_reg + CW'(1);
            end
            lps_pkg::ST_SCAN_CMP:
            begin
                if (hit) found_next = 1'b1;
                else     idx_next   = idx_reg + AW'(1);
            end
            default:
            begin
                occ_next = occ_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lps_pkg::ST_IDLE;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        err_reg   <= err_next;
        at_reg    <= at_next;
        idx_reg   <= idx_next;
        val_reg   <= val_next;
        data_reg  <= data_next;
        found_reg <= found_next;
    end

endmodule

// ===== rtl/lps_chk.sv =====
module lps_chk #(
    parameter int DEPTH = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] rsp_data,
    input logic [4:0]  rsp_count,
    input logic        rsp_found,
    input logic [1:0]  rsp_error
);

    // one request at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in progress");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (DEPTH > 31) || (int'(rsp_count) <= DEPTH))
        else $error("count above depth");

    a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_error == lps_pkg::ERR_EMPTY) |->
            (rsp_data == '0) && (rsp_count == '0) && !rsp_found)
        else $error("empty error with data or nonzero count");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_found |-> (rsp_error == lps_pkg::ERR_OK) && (rsp_data == '0))
        else $error("found flag on a failing or data-carrying beat");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) && $stable(rsp_count))
        else $error("stalled result beat changed");

endmodule

bind positional_list_store_top lps_chk #(
    .DEPTH (DEPTH)
) u_lps_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data),
    .rsp_count (rsp.count),
    .rsp_found (rsp.found),
    .rsp_error (rsp.error)
);
